### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ODRLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every edge, reset included
`define ODRLM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/odrlm_pkg.sv
package odrlm_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 12;
    localparam int PERIOD_W  = 10;
    localparam int CFG_IDX_W = 3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] source_sample;
        logic [SAMPLE_W-1:0] out_volt_sample;
        logic [SAMPLE_W-1:0] out_curr_sample;
    } t_in;

    typedef struct packed {
        logic [6:0] pwm_compare;
        logic       load_pin;
        logic       dummy_pin;
        logic       overcurrent;
        logic [2:0] restarts;
    } t_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_MIN,
        CFG_LIGHT_BAND_LOW,
        CFG_LIGHT_BAND_HIGH,
        CFG_HEAVY_BAND_LOW,
        CFG_HEAVY_BAND_HIGH,
        CFG_CURRENT_SPLIT,
        CFG_OVERCURRENT_LIMIT,
        CFG_STAGE_PERIOD
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] source_min;
        logic [CFG_W-1:0] light_band_low;
        logic [CFG_W-1:0] light_band_high;
        logic [CFG_W-1:0] heavy_band_low;
        logic [CFG_W-1:0] heavy_band_high;
        logic [CFG_W-1:0] current_split;
        logic [CFG_W-1:0] overcurrent_limit;
    } t_reg_cfg;

    typedef struct packed {
        t_reg_cfg            band;
        logic [PERIOD_W-1:0] stage_period;
    } t_cfg;

    localparam t_cfg CFG_RESET = {
        12'd460, 12'd581, 12'd598, 12'd592, 12'd609, 12'd745, 12'd1241, 10'd300
    };

    typedef struct packed {
        logic [6:0] compare;
        logic       overcurrent;
    } t_reg_result;

    typedef struct packed {
        logic       load_off;
        logic       dummy_on;
        logic [2:0] restarts;
    } t_load_status;

    // regulator constants
    localparam logic [SAMPLE_W-1:0] OV_LIGHT   = 12'd608;
    localparam logic [SAMPLE_W-1:0] OV_HEAVY   = 12'd618;
    localparam logic [SAMPLE_W-1:0] SOFT_VOLT  = 12'd553;
    localparam int                  SOFT_DUTY  = 98;
    localparam logic [6:0]          OC_COMPARE = 7'd10;

    // load hand-off constants
    localparam logic [SAMPLE_W-1:0] ATTACH_VOLT      = 12'd541;
    localparam logic [SAMPLE_W-1:0] ATTACH_CURR      = 12'd50;
    localparam logic [SAMPLE_W-1:0] LIGHT_CURR_LO    = 12'd30;
    localparam logic [SAMPLE_W-1:0] LIGHT_CURR_HI    = 12'd199;
    localparam logic [SAMPLE_W-1:0] HEAVY_CURR       = 12'd223;
    localparam logic [9:0]          LIGHT_LIMIT      = 10'd600;
    localparam logic [10:0]         STOP_LIMIT_EARLY = 11'd236;
    localparam logic [10:0]         STOP_LIMIT_LATE  = 11'd1036;
    localparam logic [2:0]          RESTART_EARLY    = 3'd3;
    localparam logic [2:0]          RESTART_MAX      = 3'd6;

endpackage

### rtl/odrlm_regulator.sv
`include "assert_macros.svh"

module odrlm_regulator
    import odrlm_pkg::*;
#(
    parameter int DUTY_MAX = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  t_reg_cfg            i_cfg,
    input  t_in                 i_prev,
    input  logic [SAMPLE_W-1:0] i_fresh_volt,
    input  logic [SAMPLE_W-1:0] i_fresh_curr,
    output t_reg_result         o_result
);

    localparam int DUTY_TOP = (DUTY_MAX > SOFT_DUTY + 1) ? DUTY_MAX : SOFT_DUTY + 1;
    localparam int DW       = $clog2(DUTY_TOP + 1);

    logic [DW-1:0]       r_duty;
    logic [DW-1:0]       n_duty;
    logic                r_started;
    logic                n_started;

    logic                heavy;
    logic                run;
    logic                hold;
    logic                rise;
    logic                ov;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [DW:0]         step;
    logic [DW-1:0]       reg_duty;
    logic [6:0]          compare;
    logic                oc;

    always_comb begin
        heavy = i_prev.out_curr_sample > i_cfg.current_split;
        run   = i_prev.source_sample >= i_cfg.source_min;
        lo    = heavy ? i_cfg.heavy_band_low  : i_cfg.light_band_low;
        hi    = heavy ? i_cfg.heavy_band_high : i_cfg.light_band_high;
        hold  = (i_prev.out_volt_sample > lo) && (i_prev.out_volt_sample < hi);
        rise  = !hold && (i_prev.out_volt_sample <= lo);

        if (hold) begin
            step = {1'b0, r_duty};
        end else if (rise) begin
            step = {1'b0, r_duty} + (DW+1)'(1);
        end else if (r_duty != '0) begin
            step = {1'b0, r_duty} - (DW+1)'(1);
        end else begin
            step = '0;
        end
        if (step > (DW+1)'(DUTY_MAX)) begin
            step = (DW+1)'(DUTY_MAX);
        end

        ov = heavy ? (i_prev.out_volt_sample > OV_HEAVY)
                   : (i_prev.out_volt_sample > OV_LIGHT);
        if (ov) begin
            reg_duty = (step > (DW+1)'(1)) ? DW'(step - (DW+1)'(2)) : '0;
        end else begin
            reg_duty = DW'(step);
        end

        if (run) begin
            compare = reg_duty[6:0];
        end else begin
            reg_duty = r_duty;
            compare  = '0;
        end

        // one-time soft-start bump
        n_duty    = reg_duty;
        n_started = r_started;
        if ((i_fresh_volt < SOFT_VOLT) && !r_started) begin
            if (reg_duty < DW'(SOFT_DUTY)) begin
                n_duty  = reg_duty + DW'(2);
                compare = n_duty[6:0];
            end
            n_started = 1'b1;
        end

        oc = i_fresh_curr > i_cfg.overcurrent_limit;
        if (oc) begin
            compare = OC_COMPARE;
        end

        o_result.compare     = compare;
        o_result.overcurrent = oc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty    <= DW'(1);
            r_started <= 1'b0;
        end else if (i_fire) begin
            r_duty    <= n_duty;
            r_started <= n_started;
        end
    end

    `ODRLM_ASSERT(a_duty_range, r_duty <= DW'(DUTY_TOP), "duty beyond its range")
    `ODRLM_ASSERT(a_started_sticks, r_started |=> r_started, "soft-start flag cleared")

endmodule

### rtl/odrlm_load_ctrl.sv
`include "assert_macros.svh"

module odrlm_load_ctrl
    import odrlm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic [SAMPLE_W-1:0] i_prev_volt,
    input  logic [SAMPLE_W-1:0] i_prev_curr,
    input  logic [SAMPLE_W-1:0] i_fresh_curr,
    output t_load_status        o_status
);

    logic [PERIOD_W-1:0] r_pass;
    logic [PERIOD_W-1:0] n_pass;
    logic [1:0]          r_attach;
    logic [1:0]          n_attach;
    logic [9:0]          r_light;
    logic [9:0]          n_light;
    logic [10:0]         r_stop;
    logic [10:0]         n_stop;
    logic [2:0]          r_restart;
    logic [2:0]          n_restart;
    logic                r_dummy_on;
    logic                n_dummy_on;
    logic                r_load_off;
    logic                n_load_off;

    logic [PERIOD_W:0]   pass_inc;
    logic                stage;
    logic [2:0]          attach;
    logic [10:0]         stop_limit;

    always_comb begin
        pass_inc = {1'b0, r_pass} + (PERIOD_W+1)'(1);
        stage    = pass_inc > {1'b0, i_period};
        n_pass   = stage ? PERIOD_W'(1) : pass_inc[PERIOD_W-1:0];

        attach     = {1'b0, r_attach};
        n_dummy_on = r_dummy_on;
        n_load_off = r_load_off;

        // stage check on the stored samples
        if (stage && r_dummy_on) begin
            if ((i_prev_curr > ATTACH_CURR) && (i_prev_volt > ATTACH_VOLT)) begin
                attach = attach + 3'd1;
            end
            if (i_prev_curr < ATTACH_CURR) begin
                attach = 3'd1;
            end
            if (attach > 3'd3) begin
                n_dummy_on = 1'b0;
                n_load_off = 1'b0;
                attach     = 3'd1;
            end
        end
        n_attach = attach[1:0];

        // low-current shutdown on the fresh current sample
        n_light    = r_light;
        n_stop     = r_stop;
        n_restart  = r_restart;
        stop_limit = (r_restart < RESTART_EARLY) ? STOP_LIMIT_EARLY : STOP_LIMIT_LATE;
        if (!n_dummy_on) begin
            if ((i_fresh_curr > LIGHT_CURR_LO) && (i_fresh_curr < LIGHT_CURR_HI)) begin
                n_light = n_light + 10'd1;
            end
            if (i_fresh_curr > HEAVY_CURR) begin
                n_light = 10'd1;
            end
            if (n_light > LIGHT_LIMIT) begin
                n_stop  = n_stop + 11'd1;
                n_light = 10'd1;
            end
            if (n_stop > stop_limit) begin
                n_load_off = 1'b1;
                n_dummy_on = 1'b1;
                n_stop     = 11'd1;
                n_restart  = n_restart + 3'd1;
            end
        end
        if (n_restart > RESTART_MAX) begin
            n_restart = '0;
        end

        o_status.load_off = n_load_off;
        o_status.dummy_on = n_dummy_on;
        o_status.restarts = n_restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass     <= PERIOD_W'(1);
            r_attach   <= '0;
            r_light    <= 10'd1;
            r_stop     <= 11'd1;
            r_restart  <= '0;
            r_dummy_on <= 1'b1;
            r_load_off <= 1'b1;
        end else if (i_fire) begin
            r_pass     <= n_pass;
            r_attach   <= n_attach;
            r_light    <= n_light;
            r_stop     <= n_stop;
            r_restart  <= n_restart;
            r_dummy_on <= n_dummy_on;
            r_load_off <= n_load_off;
        end
    end

    `ODRLM_ASSERT(a_pins_paired, r_dummy_on == r_load_off, "dummy and load pins disagree")
    `ODRLM_ASSERT(a_restart_range, r_restart <= RESTART_MAX, "restart count past wrap")

endmodule

### rtl/output_duty_regulator_load_manager.sv
// Duty regulator and dummy/real load hand-off. Each item carries one control
// pass worth of source voltage, output voltage and output current samples and
// gives exactly one result: the PWM compare value, both load pin levels, an
// overcurrent flag and the restart count. Regulation and the periodic stage
// check use the samples of the previous item; the soft-start bump, the
// overcurrent override and the low-current shutdown use the fresh ones. An
// item is taken into an input register and worked by compares, increments and
// muxes into a result register; the block accepts one item every cycle while
// results are taken, and a result is offered once its item has reached the
// result register. A held result stalls the input only once the input
// register is also full. The user must write configuration registers through
// the plain write port while the block is idle; the block does not enforce
// this. DUTY_MAX sets the duty clamp and the width of the duty register.
`include "assert_macros.svh"

module output_duty_regulator_load_manager
    import odrlm_pkg::*;
#(
    parameter int DUTY_MAX = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data
);

    t_cfg         r_cfg;
    logic         r_in_valid;
    t_in          r_in;
    t_in          r_prev;
    logic         r_out_valid;
    t_out         r_out;

    logic         fire;
    logic         in_accept;
    t_reg_result  reg_result;
    t_load_status load_status;

    assign fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wen) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_MIN:        r_cfg.band.source_min        <= i_cfg_data;
                CFG_LIGHT_BAND_LOW:    r_cfg.band.light_band_low    <= i_cfg_data;
                CFG_LIGHT_BAND_HIGH:   r_cfg.band.light_band_high   <= i_cfg_data;
                CFG_HEAVY_BAND_LOW:    r_cfg.band.heavy_band_low    <= i_cfg_data;
                CFG_HEAVY_BAND_HIGH:   r_cfg.band.heavy_band_high   <= i_cfg_data;
                CFG_CURRENT_SPLIT:     r_cfg.band.current_split     <= i_cfg_data;
                CFG_OVERCURRENT_LIMIT: r_cfg.band.overcurrent_limit <= i_cfg_data;
                CFG_STAGE_PERIOD:      r_cfg.stage_period <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
    end

    // samples kept for the next pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (fire) begin
            r_prev <= r_in;
        end
    end

    odrlm_regulator #(
        .DUTY_MAX (DUTY_MAX)
    ) u_regulator (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_cfg        (r_cfg.band),
        .i_prev       (r_prev),
        .i_fresh_volt (r_in.out_volt_sample),
        .i_fresh_curr (r_in.out_curr_sample),
        .o_result     (reg_result)
    );

    odrlm_load_ctrl u_load_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_period     (r_cfg.stage_period),
        .i_prev_volt  (r_prev.out_volt_sample),
        .i_prev_curr  (r_prev.out_curr_sample),
        .i_fresh_curr (r_in.out_curr_sample),
        .o_status     (load_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.pwm_compare <= reg_result.compare;
            r_out.overcurrent <= reg_result.overcurrent;
            r_out.load_pin    <= load_status.load_off;
            r_out.dummy_pin   <= load_status.dummy_on;
            r_out.restarts    <= load_status.restarts;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ODRLM_ASSERT(a_fire_loads_result, fire |=> o_out_valid, "worked item gave no result")
    `ODRLM_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid && !r_in_valid, "not empty after reset")
    `ODRLM_ASSERT(a_oc_compare, fire && reg_result.overcurrent |=> o_out_data.pwm_compare == OC_COMPARE, "overcurrent compare lost")

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import odrlm_pkg::*;

    localparam int DUTY_MAX    = 100;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASE_ITEMS = 185;
    localparam int NUM_PHASES  = 10;
    localparam int MAX_REPORTS = 10;

    localparam logic [10:0] RX_PATTERN_BITS = 11'b110_1011_0011;

    typedef enum logic [1:0] {TREND_DOWN, TREND_UP, TREND_HOLD} t_trend;
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} t_rx_mode;
    typedef enum int {
        KIND_RESET, KIND_ZERO, KIND_MAX, KIND_CROSSED, KIND_NEAR, KIND_WILD
    } t_cfg_kind;

    class duty_load_scoreboard;
        logic [CFG_W-1:0]    regs [8];
        logic [6:0]          duty;
        t_trend              trend;
        logic [SAMPLE_W-1:0] prev_source;
        logic [SAMPLE_W-1:0] prev_volt;
        logic [SAMPLE_W-1:0] prev_curr;
        logic [PERIOD_W-1:0] pass_count;
        logic [7:0]          attach_count;
        logic [9:0]          light_count;
        logic [10:0]         stop_count;
        logic [2:0]          restart_count;
        logic                started;
        logic                dummy_on;
        logic                load_off;
        t_out                expected_results [$];
        int                  mismatches;
        int                  checked;

        function new();
            regs[CFG_SOURCE_MIN]        = CFG_RESET.band.source_min;
            regs[CFG_LIGHT_BAND_LOW]    = CFG_RESET.band.light_band_low;
            regs[CFG_LIGHT_BAND_HIGH]   = CFG_RESET.band.light_band_high;
            regs[CFG_HEAVY_BAND_LOW]    = CFG_RESET.band.heavy_band_low;
            regs[CFG_HEAVY_BAND_HIGH]   = CFG_RESET.band.heavy_band_high;
            regs[CFG_CURRENT_SPLIT]     = CFG_RESET.band.current_split;
            regs[CFG_OVERCURRENT_LIMIT] = CFG_RESET.band.overcurrent_limit;
            regs[CFG_STAGE_PERIOD]      = {2'b00, CFG_RESET.stage_period};
            duty          = 7'd1;
            trend         = TREND_DOWN;
            prev_source   = '0;
            prev_volt     = '0;
            prev_curr     = '0;
            pass_count    = 10'd1;
            attach_count  = 8'd0;
            light_count   = 10'd1;
            stop_count    = 11'd1;
            restart_count = 3'd0;
            started       = 1'b0;
            dummy_on      = 1'b1;
            load_off      = 1'b1;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            regs[idx] = (idx == CFG_STAGE_PERIOD) ? {2'b00, value[PERIOD_W-1:0]} : value;
        endfunction

        function void note_item(t_in item);
            logic                heavy;
            logic [SAMPLE_W-1:0] lo;
            logic [SAMPLE_W-1:0] hi;
            logic [PERIOD_W:0]   next_pass;
            logic [6:0]          compare;
            logic                oc;
            logic [10:0]         stop_limit;
            t_out                res;

            // regulation works on the samples of the previous item
            heavy = prev_curr > regs[CFG_CURRENT_SPLIT];
            if (prev_source < regs[CFG_SOURCE_MIN]) begin
                compare = 7'd0;
            end else begin
                lo = heavy ? regs[CFG_HEAVY_BAND_LOW] : regs[CFG_LIGHT_BAND_LOW];
                hi = heavy ? regs[CFG_HEAVY_BAND_HIGH] : regs[CFG_LIGHT_BAND_HIGH];
                if (prev_volt >= hi) trend = TREND_DOWN;
                if (prev_volt <= lo) trend = TREND_UP;
                if (prev_volt > lo && prev_volt < hi) trend = TREND_HOLD;
                if (trend == TREND_DOWN) begin
                    if (duty != 7'd0) duty = duty - 7'd1;
                end else if (trend == TREND_UP) begin
                    duty = duty + 7'd1;
                end
                if (duty > DUTY_MAX) duty = 7'(DUTY_MAX);
                if ((prev_volt > OV_LIGHT && !heavy) || (prev_volt > OV_HEAVY && heavy)) begin
                    duty = (duty > 7'd1) ? duty - 7'd2 : 7'd0;
                end
                compare = duty;
            end

            // periodic dummy load stage check
            next_pass = {1'b0, pass_count} + 11'd1;
            if (next_pass > regs[CFG_STAGE_PERIOD]) begin
                next_pass = 11'd1;
                if (dummy_on) begin
                    if (prev_curr > ATTACH_CURR && prev_volt > ATTACH_VOLT) begin
                        attach_count = attach_count + 8'd1;
                    end
                    if (prev_curr < ATTACH_CURR) attach_count = 8'd1;
                    if (attach_count > 8'd3) begin
                        dummy_on     = 1'b0;
                        load_off     = 1'b0;
                        attach_count = 8'd1;
                    end
                end
            end
            pass_count = next_pass[PERIOD_W-1:0];

            prev_source = item.source_sample;
            prev_volt   = item.out_volt_sample;
            prev_curr   = item.out_curr_sample;

            oc = 1'b0;
            if (prev_volt < SOFT_VOLT && !started) begin
                if (duty < SOFT_DUTY) begin
                    duty    = duty + 7'd2;
                    compare = duty;
                end
                started = 1'b1;
            end
            if (prev_curr > regs[CFG_OVERCURRENT_LIMIT]) begin
                compare = OC_COMPARE;
                oc      = 1'b1;
            end

            // low current shutdown and restart
            if (!dummy_on) begin
                if (prev_curr > LIGHT_CURR_LO && prev_curr < LIGHT_CURR_HI) begin
                    light_count = light_count + 10'd1;
                end
                if (prev_curr > HEAVY_CURR) light_count = 10'd1;
                if (light_count > LIGHT_LIMIT) begin
                    stop_count  = stop_count + 11'd1;
                    light_count = 10'd1;
                end
                stop_limit = (restart_count < RESTART_EARLY) ? STOP_LIMIT_EARLY : STOP_LIMIT_LATE;
                if (stop_count > stop_limit) begin
                    load_off      = 1'b1;
                    dummy_on      = 1'b1;
                    stop_count    = 11'd1;
                    restart_count = restart_count + 3'd1;
                end
            end
            if (restart_count > RESTART_MAX) restart_count = 3'd0;

            res.pwm_compare = compare;
            res.load_pin    = load_off;
            res.dummy_pin   = dummy_on;
            res.overcurrent = oc;
            res.restarts    = restart_count;
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d arrived with no item outstanding", checked);
                end
                return;
            end
            want = expected_results.pop_front();
            if (got.pwm_compare !== want.pwm_compare || got.load_pin !== want.load_pin ||
                got.dummy_pin !== want.dummy_pin || got.overcurrent !== want.overcurrent ||
                got.restarts !== want.restarts) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result %0d: expected compare %0d load %0b dummy %0b oc %0b rst %0d",
                             checked, want.pwm_compare, want.load_pin, want.dummy_pin,
                             want.overcurrent, want.restarts);
                    $display("result %0d: actual   compare %0d load %0b dummy %0b oc %0b rst %0d",
                             checked, got.pwm_compare, got.load_pin, got.dummy_pin,
                             got.overcurrent, got.restarts);
                end
            end
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_wen   = 1'b0;
    t_cfg_idx cfg_index = CFG_SOURCE_MIN;
    logic [CFG_W-1:0] cfg_data = '0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_in      in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_out     out_data;

    duty_load_scoreboard sb = new();
    int       burst_left = 0;
    int       hold_left  = 0;
    bit       tx_gappy   = 1'b0;
    t_rx_mode rx_mode    = RX_ALWAYS;

    output_duty_regulator_load_manager #(
        .DUTY_MAX(DUTY_MAX)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        end
    end

    initial begin
        int rx_tick;
        rx_tick = 0;
        forever begin
            @(negedge clk);
            rx_tick++;
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_RANDOM:  out_ready <= ($urandom_range(9, 0) < 7);
                    RX_PATTERN: out_ready <= RX_PATTERN_BITS[rx_tick % 11];
                    default:    out_ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample(int lo, int hi);
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    function automatic t_in mk_item(int src, int volt, int curr);
        t_in item;
        item.source_sample   = SAMPLE_W'(src);
        item.out_volt_sample = SAMPLE_W'(volt);
        item.out_curr_sample = SAMPLE_W'(curr);
        return item;
    endfunction

    function automatic t_in rand_item();
        t_in item;
        if ($urandom_range(99, 0) < 15) begin
            item = mk_item(pick_sample(0, 4095), pick_sample(0, 4095), pick_sample(0, 4095));
        end else begin
            item.source_sample = ($urandom_range(9, 0) == 0) ? pick_sample(0, 600)
                                                              : pick_sample(400, 4095);
            item.out_volt_sample = ($urandom_range(9, 0) == 0) ? pick_sample(0, 4095)
                                                                : pick_sample(520, 650);
            case ($urandom_range(9, 0))
                0, 1:    item.out_curr_sample = pick_sample(0, 60);
                2, 3:    item.out_curr_sample = pick_sample(700, 1300);
                default: item.out_curr_sample = pick_sample(30, 260);
            endcase
        end
        return item;
    endfunction

    task automatic send_item(t_in item);
        int gap;
        if (tx_gappy && hold_left == 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(6, 1);
                repeat (gap) begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                end
                burst_left = $urandom_range(24, 1);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(posedge clk);
        end while (!in_ready);
        sb.note_item(item);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic apply_config(t_cfg_kind kind);
        logic [CFG_W-1:0] vals [8];
        t_cfg_idx         r;
        wait_drain();
        repeat (4) @(posedge clk);
        case (kind)
            KIND_RESET: begin
                vals[CFG_SOURCE_MIN]        = CFG_RESET.band.source_min;
                vals[CFG_LIGHT_BAND_LOW]    = CFG_RESET.band.light_band_low;
                vals[CFG_LIGHT_BAND_HIGH]   = CFG_RESET.band.light_band_high;
                vals[CFG_HEAVY_BAND_LOW]    = CFG_RESET.band.heavy_band_low;
                vals[CFG_HEAVY_BAND_HIGH]   = CFG_RESET.band.heavy_band_high;
                vals[CFG_CURRENT_SPLIT]     = CFG_RESET.band.current_split;
                vals[CFG_OVERCURRENT_LIMIT] = CFG_RESET.band.overcurrent_limit;
                vals[CFG_STAGE_PERIOD]      = {2'b00, CFG_RESET.stage_period};
            end
            KIND_ZERO: begin
                foreach (vals[i]) vals[i] = '0;
            end
            KIND_MAX: begin
                foreach (vals[i]) vals[i] = '1;
            end
            KIND_CROSSED: begin
                vals[CFG_SOURCE_MIN]        = pick_sample(300, 600);
                vals[CFG_LIGHT_BAND_LOW]    = pick_sample(560, 700);
                vals[CFG_LIGHT_BAND_HIGH]   = pick_sample(500, vals[CFG_LIGHT_BAND_LOW]);
                vals[CFG_HEAVY_BAND_LOW]    = pick_sample(560, 700);
                vals[CFG_HEAVY_BAND_HIGH]   = pick_sample(500, vals[CFG_HEAVY_BAND_LOW]);
                vals[CFG_CURRENT_SPLIT]     = pick_sample(100, 900);
                vals[CFG_OVERCURRENT_LIMIT] = pick_sample(150, 1500);
                vals[CFG_STAGE_PERIOD]      = pick_sample(1, 4);
            end
            KIND_NEAR: begin
                vals[CFG_SOURCE_MIN]        = pick_sample(300, 600);
                vals[CFG_LIGHT_BAND_LOW]    = pick_sample(560, 700);
                vals[CFG_LIGHT_BAND_HIGH]   = vals[CFG_LIGHT_BAND_LOW] + pick_sample(1, 30);
                vals[CFG_HEAVY_BAND_LOW]    = pick_sample(560, 700);
                vals[CFG_HEAVY_BAND_HIGH]   = vals[CFG_HEAVY_BAND_LOW] + pick_sample(1, 30);
                vals[CFG_CURRENT_SPLIT]     = pick_sample(100, 900);
                vals[CFG_OVERCURRENT_LIMIT] = pick_sample(150, 1500);
                vals[CFG_STAGE_PERIOD]      = ($urandom_range(9, 0) == 0) ? pick_sample(1, 1023)
                                                                          : pick_sample(1, 6);
            end
            default: begin
                foreach (vals[i]) vals[i] = pick_sample(0, 4095);
            end
        endcase
        r = r.first();
        do begin
            @(negedge clk);
            cfg_wen   <= 1'b1;
            cfg_index <= r;
            cfg_data  <= vals[r];
            @(posedge clk);
            sb.set_reg(r, vals[r]);
            r = r.next();
        end while (r != r.first());
        @(negedge clk);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        t_cfg_kind   phase_kinds [NUM_PHASES];

        phase_kinds = '{KIND_RESET, KIND_NEAR, KIND_CROSSED, KIND_ZERO, KIND_NEAR,
                        KIND_MAX, KIND_WILD, KIND_NEAR, KIND_CROSSED, KIND_NEAR};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // soft start, band edges, source threshold, overvoltage and overcurrent
        rx_mode  = RX_RANDOM;
        tx_gappy = 1'b0;
        send_item(mk_item(0, 0, 0));
        send_item(mk_item(4095, 581, 100));
        send_item(mk_item(4095, 598, 100));
        send_item(mk_item(4095, 590, 100));
        send_item(mk_item(4095, 4095, 0));
        send_item(mk_item(4095, 600, 800));
        send_item(mk_item(4095, 592, 800));
        send_item(mk_item(4095, 609, 4095));
        send_item(mk_item(4095, 619, 1241));
        send_item(mk_item(4095, 0, 1242));
        send_item(mk_item(459, 4095, 745));
        send_item(mk_item(460, 609, 746));
        repeat (6) send_item(mk_item(4095, 4095, 0));
        send_item(mk_item(2730, 2730, 1365));
        send_item(mk_item(1365, 1365, 2730));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            apply_config(phase_kinds[phase]);
            rx_mode  = t_rx_mode'(phase % 4);
            tx_gappy = (phase % 3) != 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == 2 && k == 40) hold_left = 400;
                if (phase == 5 && k == 90) wait_drain();
                send_item(rand_item());
            end
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
